[hw/rtl/tron_pkg.sv]
// ----------------------------------------------------------------------------
// tron_pkg
// Shared types, protocol constants and the offer table for the Telnet
// receive-side option negotiator.
// ----------------------------------------------------------------------------
package tron_pkg;

  // Number of option bits kept in each bitmap (8 to 64).
  localparam int OPT_COUNT = 32;
  localparam int OPT_IW    = $clog2(OPT_COUNT);

  // Telnet command bytes.
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;

  // Option numbers that this end supports.
  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;

  // Bit positions of the supported options in the bitmaps.
  localparam int IDX_BINARY = 0;
  localparam int IDX_ECHO   = 1;
  localparam int IDX_SGA    = 3;

  // Job kinds passed from the parser to the output sequencer.
  localparam logic [1:0] JOB_DATA  = 2'd0;
  localparam logic [1:0] JOB_REPLY = 2'd1;
  localparam logic [1:0] JOB_OFFER = 2'd2;

  // Job queue depth.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Offer sequence length and sequencer step width.
  localparam int OFFER_LEN = 15;
  localparam int STEP_W    = $clog2(OFFER_LEN);

  // Result destinations.
  localparam logic DEST_DATA  = 1'b0;
  localparam logic DEST_REPLY = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       out_dest;
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] verb;
    logic [7:0] val;
  } job_t;

  // Bytes sent on a new connection: WILL SGA, DO SGA, WILL ECHO,
  // WILL BINARY, DO BINARY, each as IAC verb option.
  function automatic logic [7:0] offer_byte(input logic [STEP_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      STEP_W'(0), STEP_W'(3), STEP_W'(6), STEP_W'(9), STEP_W'(12): b = B_IAC;
      STEP_W'(1), STEP_W'(7), STEP_W'(10): b = B_WILL;
      STEP_W'(4), STEP_W'(13): b = B_DO;
      STEP_W'(2), STEP_W'(5): b = OPT_SGA;
      STEP_W'(8): b = OPT_ECHO;
      STEP_W'(11), STEP_W'(14): b = OPT_BINARY;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

[hw/rtl/tron_front.sv]
// ----------------------------------------------------------------------------
// tron_front
// Byte parser and option negotiation. Takes one item per cycle while accept
// is high, updates parse state and option bitmaps, pushes at most one job.
// ----------------------------------------------------------------------------
module tron_front import tron_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output logic     job_push,
  output job_t     job
);

  // Parse state codes.
  localparam logic [3:0] ST_DATA  = 4'd0;
  localparam logic [3:0] ST_IAC   = 4'd1;
  localparam logic [3:0] ST_DONT  = 4'd2;
  localparam logic [3:0] ST_DO    = 4'd3;
  localparam logic [3:0] ST_WONT  = 4'd4;
  localparam logic [3:0] ST_WILL  = 4'd5;
  localparam logic [3:0] ST_SBID  = 4'd6;
  localparam logic [3:0] ST_SB    = 4'd7;
  localparam logic [3:0] ST_SBIAC = 4'd8;

  // Printable data window, low bound inclusive and high bound exclusive.
  localparam logic [7:0] DATA_LO = 8'd3;
  localparam logic [7:0] DATA_HI = 8'd127;

  logic [3:0]           state_r, state_nxt;
  logic [OPT_COUNT-1:0] local_r, local_nxt;
  logic [OPT_COUNT-1:0] remote_r, remote_nxt;
  logic                 binary_r, binary_nxt;

  logic                 neg_req;
  logic                 neg_remote;
  logic                 neg_on;
  logic [7:0]           neg_verb;
  logic [OPT_IW-1:0]    opt_idx;
  logic                 cur_bit;
  logic [7:0]           c;

  assign c       = item.rx_byte;
  assign opt_idx = c[OPT_IW-1:0];

  // Parser and negotiation decision for the current item.
  always_comb begin
    state_nxt  = state_r;
    local_nxt  = local_r;
    remote_nxt = remote_r;
    binary_nxt = binary_r;
    job_push   = 1'b0;
    job        = '0;
    neg_req    = 1'b0;
    neg_remote = 1'b0;
    neg_on     = 1'b0;
    neg_verb   = B_WONT;
    cur_bit    = 1'b0;

    if (item.action) begin
      // New connection: clear everything, then claim the offered options.
      state_nxt              = ST_DATA;
      local_nxt              = '0;
      remote_nxt             = '0;
      binary_nxt             = 1'b0;
      local_nxt[IDX_SGA]     = 1'b1;
      local_nxt[IDX_ECHO]    = 1'b1;
      local_nxt[IDX_BINARY]  = 1'b1;
      remote_nxt[IDX_SGA]    = 1'b1;
      remote_nxt[IDX_BINARY] = 1'b1;
      job_push               = 1'b1;
      job.kind               = JOB_OFFER;
    end else begin
      case (state_r)
        ST_DATA: begin
          if (c == B_IAC) begin
            state_nxt = ST_IAC;
          end else if (binary_r || (c >= DATA_LO && c < DATA_HI)) begin
            job_push = 1'b1;
            job.kind = JOB_DATA;
            job.val  = c;
          end
        end
        ST_IAC: begin
          if (c == B_IAC) begin
            // Escaped IAC passes only in binary mode.
            if (binary_r) begin
              job_push = 1'b1;
              job.kind = JOB_DATA;
              job.val  = B_IAC;
            end
            state_nxt = ST_DATA;
          end else if (c == B_DONT) begin
            state_nxt = ST_DONT;
          end else if (c == B_DO) begin
            state_nxt = ST_DO;
          end else if (c == B_WONT) begin
            state_nxt = ST_WONT;
          end else if (c == B_WILL) begin
            state_nxt = ST_WILL;
          end else if (c == B_SB) begin
            state_nxt = ST_SBID;
          end else begin
            state_nxt = ST_DATA;
          end
        end
        ST_DONT: begin
          neg_req   = 1'b1;
          neg_verb  = B_WONT;
          state_nxt = ST_DATA;
        end
        ST_DO: begin
          neg_req   = 1'b1;
          neg_on    = (c == OPT_SGA) || (c == OPT_ECHO) || (c == OPT_BINARY);
          neg_verb  = neg_on ? B_WILL : B_WONT;
          state_nxt = ST_DATA;
        end
        ST_WONT: begin
          neg_req    = 1'b1;
          neg_remote = 1'b1;
          neg_verb   = B_DONT;
          state_nxt  = ST_DATA;
        end
        ST_WILL: begin
          neg_req    = 1'b1;
          neg_remote = 1'b1;
          neg_on     = (c == OPT_SGA) || (c == OPT_BINARY);
          neg_verb   = neg_on ? B_DO : B_DONT;
          if (c == OPT_BINARY) begin
            binary_nxt = 1'b1;
          end
          state_nxt  = ST_DATA;
        end
        ST_SBID: begin
          state_nxt = ST_SB;
        end
        ST_SB: begin
          if (c == B_IAC) begin
            state_nxt = ST_SBIAC;
          end
        end
        ST_SBIAC: begin
          state_nxt = (c == B_SE) ? ST_DATA : ST_SB;
        end
        default: begin
          state_nxt = ST_DATA;
        end
      endcase

      // Flip the option bit and reply only when it actually changes.
      if (neg_req && (c < 8'(OPT_COUNT))) begin
        cur_bit = neg_remote ? remote_r[opt_idx] : local_r[opt_idx];
        if (cur_bit != neg_on) begin
          if (neg_remote) begin
            remote_nxt[opt_idx] = neg_on;
          end else begin
            local_nxt[opt_idx] = neg_on;
          end
          job_push = 1'b1;
          job.kind = JOB_REPLY;
          job.verb = neg_verb;
          job.val  = c;
        end
      end
    end

    // Nothing moves without an accepted item.
    if (!accept) begin
      job_push = 1'b0;
    end
  end

  // Parser state and option bitmaps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_DATA;
      local_r  <= '0;
      remote_r <= '0;
      binary_r <= 1'b0;
    end else if (accept) begin
      state_r  <= state_nxt;
      local_r  <= local_nxt;
      remote_r <= remote_nxt;
      binary_r <= binary_nxt;
    end
  end

endmodule

[hw/rtl/tron_queue.sv]
// ----------------------------------------------------------------------------
// tron_queue
// Short job queue between the parser and the output sequencer.
// ----------------------------------------------------------------------------
module tron_queue import tron_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t rd_job
);

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QCW-1:0] count_r;
  logic           do_push;
  logic           do_pop;

  assign full    = (count_r == QCW'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = mem_r[rd_ptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/tron_back.sv]
// ----------------------------------------------------------------------------
// tron_back
// Output sequencer. Expands the head job of the queue into result bytes,
// one per cycle unless held by a full stage, into a registered output stage.
// ----------------------------------------------------------------------------
module tron_back import tron_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  job_t      q_job,
  output logic      q_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);

  logic              out_valid_r;
  out_item_t         out_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  out_item_t         res;
  logic              load;

  // Result byte for the current step of the head job.
  always_comb begin
    res = '0;
    case (q_job.kind)
      JOB_DATA: begin
        res.out_dest = DEST_DATA;
        res.out_byte = q_job.val;
        res.out_last = 1'b1;
      end
      JOB_REPLY: begin
        res.out_dest = DEST_REPLY;
        res.out_last = (step_r == STEP_W'(2));
        if (step_r == STEP_W'(0)) begin
          res.out_byte = B_IAC;
        end else if (step_r == STEP_W'(1)) begin
          res.out_byte = q_job.verb;
        end else begin
          res.out_byte = q_job.val;
        end
      end
      JOB_OFFER: begin
        res.out_dest = DEST_REPLY;
        res.out_byte = offer_byte(step_r);
        res.out_last = (step_r == STEP_W'(OFFER_LEN - 1));
      end
      default: begin
        res.out_dest = DEST_DATA;
        res.out_byte = q_job.val;
        res.out_last = 1'b1;
      end
    endcase
  end

  // Load the output stage when a job waits and the stage is free or drained.
  assign load     = !q_empty && (!out_valid_r || out_pop);
  assign q_pop    = load && res.out_last;
  assign step_nxt = res.out_last ? '0 : step_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        step_r      <= step_nxt;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

endmodule

[hw/rtl/telnet_receive_option_negotiator.sv]
// ----------------------------------------------------------------------------
// telnet_receive_option_negotiator
// Telnet receive-side parser with option negotiation: data bytes go to the
// receive buffer, replies to the peer, both on one result queue.
//
//   Channel  Ports                         Transaction
//   input    in_push, in_full, in_item     one received byte or new connection
//   result   out_pop, out_empty, out_item  one data or reply byte
//
// The parser takes one item per cycle and is stalled only by a full job
// queue (four jobs). The output sequencer emits one byte per cycle unless
// the full output stage is not popped: a data job gives one byte, a reply
// three, a new-connection offer fifteen. Results pass the queue and stage.
// Synchronous active-low reset clears the parse state, option bitmaps,
// binary mode, the queue and the output stage.
// ----------------------------------------------------------------------------
module telnet_receive_option_negotiator import tron_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);

  logic in_accept;
  logic job_push;
  job_t job_in;
  logic q_full;
  logic q_empty;
  logic q_pop;
  job_t q_job;

  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  // Parser front end.
  tron_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .item     (in_item),
    .job_push (job_push),
    .job      (job_in)
  );

  // Job queue.
  tron_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (job_push),
    .wr_job (job_in),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_job (q_job)
  );

  // Output sequencer.
  tron_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

  // A data byte is always a transaction's only result.
  a_data_single: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.out_dest == DEST_DATA) |-> out_item.out_last)
    else $error("data result not marked last");

  // A reply always ends with an option number in range.
  a_reply_opt: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.out_dest == DEST_REPLY && out_item.out_last)
      |-> (out_item.out_byte < 8'(OPT_COUNT)))
    else $error("reply ends with an out-of-range option");

  // The rest of a multi-byte reply follows without a gap.
  a_reply_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_item.out_last) |=> !out_empty)
    else $error("gap inside a multi-byte reply");

endmodule
